### rtl/core/keypad_matrix_scanner_fifo_core_macros.svh
// Assertion macros shared by the keypad scanner core.
// Each macro samples on the rising edge of clock and is quiet while reset is high.
`ifndef KEYPAD_MATRIX_SCANNER_FIFO_CORE_MACROS_SVH
`define KEYPAD_MATRIX_SCANNER_FIFO_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define KMS_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("kms: invariant violated");
`define KMS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kms: implication violated");
`define KMS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kms: next-cycle check violated");
`else
`define KMS_ASSERT_ALWAYS(label, cond)
`define KMS_ASSERT_IMPLY(label, ante, cons)
`define KMS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/core/kms_pkg.sv
package kms_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_REPEAT_LIMIT   = 2'd0;
   localparam logic [1:0] CSR_REPEAT_RELOAD  = 2'd1;
   localparam logic [1:0] CSR_TRANSLATE_MODE = 2'd2;

   localparam logic [7:0] RESET_REPEAT_LIMIT  = 8'd25;
   localparam logic [7:0] RESET_REPEAT_RELOAD = 8'd22;

   localparam int         QCOUNT_W     = 6;
   localparam int         TABLE_LEN    = 31;
   localparam logic [7:0] RELEASE_MARK = 8'h80;
   localparam logic [7:0] UNKNOWN_CHAR = 8'h3F;

   // key code to character
   localparam logic [7:0] CHAR_TABLE [0:TABLE_LEN-1] = '{
      8'h3F, 8'h42, 8'h50, 8'h45, 8'h20, 8'h31, 8'h32, 8'h33,
      8'h74, 8'h54, 8'h34, 8'h35, 8'h36, 8'h73, 8'h53, 8'h37,
      8'h38, 8'h39, 8'h20, 8'h20, 8'h2A, 8'h30, 8'h23, 8'h76,
      8'h56, 8'h3C, 8'h3D, 8'h3E, 8'h51, 8'h20, 8'h7E
   };

   typedef enum logic [1:0] {
      KIND_SCAN,
      KIND_POP,
      KIND_SKIP
   } kms_kind_type;

   typedef struct packed {
      kms_kind_type kind;
      logic [7:0]   base;
      logic [4:0]   cols;
   } kms_cmd_type;

   typedef struct packed {
      logic [7:0] repeat_limit;
      logic [7:0] repeat_reload;
      logic       translate_mode;
   } kms_cfg_type;

   typedef struct packed {
      logic [7:0]          out_byte;
      logic                out_valid;
      logic [QCOUNT_W-1:0] queued_count;
      logic                row_keys_held;
   } kms_res_type;

   function automatic logic [7:0] kms_char(input logic [7:0] code);
      logic [7:0] ch;
      if (int'(code) < TABLE_LEN) begin
         ch = CHAR_TABLE[code[4:0]];
      end else begin
         ch = UNKNOWN_CHAR;
      end
      return ch;
   endfunction

endpackage

### rtl/core/kms_front.sv
module kms_front
   import kms_pkg::*;
#(
   parameter int ROWS    = 6,
   parameter int COLUMNS = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_func,
   input  logic [2:0]  req_row,
   input  logic [4:0]  req_cols,
   output logic        req_ready,
   output logic        q_valid,
   output kms_cmd_type q_cmd,
   input  logic        q_ready
);

   logic        valid_ff, valid_in;
   kms_cmd_type cmd_ff, cmd_in;
   logic        load;

   assign req_ready = !valid_ff || q_ready;
   assign load      = req_valid && req_ready;
   assign q_valid   = valid_ff;
   assign q_cmd     = cmd_ff;

   // classify the item and precompute the first key code of the row
   always_comb begin
      cmd_in.cols = req_cols;
      cmd_in.base = 8'(int'(req_row) * COLUMNS);
      if (req_func) begin
         cmd_in.kind = KIND_POP;
      end else if (int'(req_row) < ROWS) begin
         cmd_in.kind = KIND_SCAN;
      end else begin
         cmd_in.kind = KIND_SKIP;
      end
      valid_in = load || (valid_ff && !q_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

### rtl/core/kms_queue.sv
`include "keypad_matrix_scanner_fifo_core_macros.svh"

module kms_queue
   import kms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  kms_cmd_type in_cmd,
   output logic        in_ready,
   output logic        out_valid,
   output kms_cmd_type out_cmd,
   input  logic        out_ready
);

   kms_cmd_type entry_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = entry_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= in_cmd;
      end
   end

   `KMS_ASSERT_ALWAYS(a_queue_bound, cnt_ff != 2'd3)
   `KMS_ASSERT_IMPLY(a_queue_empty_ptrs, cnt_ff == 2'd0, wr_ff == rd_ff)
   `KMS_ASSERT_IMPLY(a_queue_full_ptrs, cnt_ff == 2'd2, wr_ff == rd_ff)

endmodule

### rtl/core/kms_back.sv
`include "keypad_matrix_scanner_fifo_core_macros.svh"

module kms_back
   import kms_pkg::*;
#(
   parameter int ROWS       = 6,
   parameter int COLUMNS    = 5,
   parameter int FIFO_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  kms_cfg_type cfg,
   input  logic        q_valid,
   input  kms_cmd_type q_cmd,
   output logic        q_ready,
   input  logic        out_free,
   output logic        res_load,
   output kms_res_type res
);

   localparam int KEYS  = ROWS * COLUMNS;
   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COL_EXEC,
      ST_PUSH2,
      ST_RESULT
   } state_type;

   state_type        state_ff, state_in;
   logic [KEY_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [4:0]       cols_ff, cols_in;
   logic             held_ff, held_in;
   logic             byte_valid_ff, byte_valid_in;
   logic [7:0]       pend_ff, pend_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             cvalid_ff [2**KEY_W];

   logic [7:0]       cnt_mem [2**KEY_W];
   logic [7:0]       cnt_rd_ff;
   logic [7:0]       fifo_mem [FIFO_DEPTH];
   logic [7:0]       fifo_rd_ff;

   logic [KEY_W-1:0] cnt_rd_addr;
   logic             cnt_wr;
   logic [7:0]       cnt_cur, cnt_fire, cnt_rel, cnt_next;
   logic [4:0]       cols_shift;
   logic             pressed, fire, rel, ev2, last_col;
   logic [7:0]       code8, byte1, byte2;
   logic             push_req, push_ok, pop_fire;
   logic [7:0]       push_byte;

   // per-key update for the column in flight
   always_comb begin
      cnt_cur    = cvalid_ff[idx_ff] ? cnt_rd_ff : 8'd0;
      cols_shift = cols_ff >> col_ff;
      pressed    = cols_shift[0];
      fire       = (pressed && cnt_cur == 8'd0) || (cnt_cur > cfg.repeat_limit);
      cnt_fire   = fire ? ((cnt_cur != 8'd0) ? cfg.repeat_reload : 8'd1) : cnt_cur;
      rel        = !pressed && cnt_fire != 8'd0;
      cnt_rel    = rel ? 8'd0 : cnt_fire;
      cnt_next   = (cnt_rel != 8'd0 && cnt_rel != 8'hFF) ? cnt_rel + 8'd1 : cnt_rel;
      ev2        = rel && !cfg.translate_mode;
      code8      = 8'(idx_ff);
      byte1      = cfg.translate_mode ? kms_char(code8) : code8;
      byte2      = code8 | RELEASE_MARK;
      last_col   = (col_ff == LAST_COL);
   end

   always_comb begin
      push_req  = 1'b0;
      push_byte = pend_ff;
      case (state_ff)
         ST_COL_EXEC: begin
            push_req  = fire || ev2;
            push_byte = fire ? byte1 : byte2;
         end
         ST_PUSH2: begin
            push_req  = 1'b1;
            push_byte = pend_ff;
         end
         default: begin
            push_req  = 1'b0;
         end
      endcase
      push_ok  = push_req && (count_ff != FULL_CNT);
      pop_fire = (state_ff == ST_IDLE) && q_valid && (q_cmd.kind == KIND_POP) &&
                 (count_ff != '0);
   end

   assign q_ready     = (state_ff == ST_IDLE);
   assign cnt_wr      = (state_ff == ST_COL_EXEC);
   assign cnt_rd_addr = (state_ff == ST_IDLE) ? q_cmd.base[KEY_W-1:0] : idx_ff + KEY_W'(1);
   assign res_load    = (state_ff == ST_RESULT) && out_free;

   always_comb begin
      res.out_byte      = byte_valid_ff ? fifo_rd_ff : 8'd0;
      res.out_valid     = byte_valid_ff;
      res.queued_count  = QCOUNT_W'(count_ff);
      res.row_keys_held = held_ff;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      cols_in       = cols_ff;
      held_in       = held_ff;
      byte_valid_in = byte_valid_ff;
      pend_in       = pend_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      count_in      = count_ff;

      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         count_in  = count_ff + CNT_W'(1);
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         count_in  = count_ff - CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               held_in       = 1'b0;
               byte_valid_in = pop_fire;
               if (q_cmd.kind == KIND_SCAN) begin
                  idx_in   = q_cmd.base[KEY_W-1:0];
                  col_in   = '0;
                  cols_in  = q_cmd.cols;
                  state_in = ST_COL_EXEC;
               end else begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_COL_EXEC: begin
            held_in = held_ff || (cnt_next != 8'd0);
            if (fire && ev2) begin
               pend_in  = byte2;
               state_in = ST_PUSH2;
            end else if (last_col) begin
               state_in = ST_RESULT;
            end else begin
               idx_in = idx_ff + KEY_W'(1);
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_PUSH2: begin
            if (last_col) begin
               state_in = ST_RESULT;
            end else begin
               idx_in   = idx_ff + KEY_W'(1);
               col_in   = col_ff + COL_W'(1);
               state_in = ST_COL_EXEC;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         for (int i = 0; i < 2**KEY_W; i++) begin
            cvalid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         if (cnt_wr) begin
            cvalid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      col_ff        <= col_in;
      cols_ff       <= cols_in;
      held_ff       <= held_in;
      byte_valid_ff <= byte_valid_in;
      pend_ff       <= pend_in;
   end

   always_ff @(posedge clock) begin
      cnt_rd_ff <= cnt_mem[cnt_rd_addr];
      if (cnt_wr) begin
         cnt_mem[idx_ff] <= cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         fifo_mem[wr_ptr_ff] <= push_byte;
      end
      if (pop_fire) begin
         fifo_rd_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   `KMS_ASSERT_ALWAYS(a_count_bound, count_ff <= FULL_CNT)
   `KMS_ASSERT_NEXT(a_drop_when_full, push_req && count_ff == FULL_CNT, $stable(wr_ptr_ff) && $stable(count_ff))
   `KMS_ASSERT_IMPLY(a_pop_not_empty, pop_fire, count_ff != '0 && !push_req)

endmodule

### rtl/core/keypad_matrix_scanner_fifo_core.sv
// The back end takes a new item only in its idle state, after the result of the last one
//   is loaded; it works through a row sample one key column per cycle, stepping through
//   ST_PUSH2 as well for each column that queues both a repeat and a release.
// Reset (synchronous, active high) clears all hold counters through per-key valid bits,
//   empties the event FIFO and the item queue, and loads the registers with 25, 22 and 1.
module keypad_matrix_scanner_fifo_core
   import kms_pkg::*;
#(
   parameter int ROWS       = 6,
   parameter int COLUMNS    = 5,
   parameter int FIFO_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // item in
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [2:0] row_index, [7:3] column_bits
   input  logic        req_tuser,   // [0] func: 0 row sample, 1 pop
   // result out
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [13:8] queued_count,
                                    // [14] row_keys_held, [15] zero
   output logic        rsp_tuser,   // [0] out_valid
   // register writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   kms_cfg_type cfg_ff, cfg_in;

   logic        front_valid, front_ready;
   kms_cmd_type front_cmd;
   logic        back_valid, back_ready;
   kms_cmd_type back_cmd;

   logic        res_load, out_free;
   kms_res_type res;

   logic        rsp_valid_ff, rsp_valid_in;
   kms_res_type rsp_ff;

   // register file: write only, taken in the cycle the enable is high
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_REPEAT_LIMIT:   cfg_in.repeat_limit   = csr_wdata;
            CSR_REPEAT_RELOAD:  cfg_in.repeat_reload  = csr_wdata;
            CSR_TRANSLATE_MODE: cfg_in.translate_mode = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.repeat_limit   <= RESET_REPEAT_LIMIT;
         cfg_ff.repeat_reload  <= RESET_REPEAT_RELOAD;
         cfg_ff.translate_mode <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: take the item and sort it into row sample, pop or ignored row
   kms_front #(
      .ROWS    (ROWS),
      .COLUMNS (COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_func  (req_tuser),
      .req_row   (req_tdata[2:0]),
      .req_cols  (req_tdata[7:3]),
      .req_ready (req_tready),
      .q_valid   (front_valid),
      .q_cmd     (front_cmd),
      .q_ready   (front_ready)
   );

   // short queue so the front keeps accepting while the back works through a row
   kms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_cmd    (front_cmd),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_cmd   (back_cmd),
      .out_ready (back_ready)
   );

   // back end: hold counters, event FIFO and the per-column sequencer
   kms_back #(
      .ROWS       (ROWS),
      .COLUMNS    (COLUMNS),
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (back_valid),
      .q_cmd    (back_cmd),
      .q_ready  (back_ready),
      .out_free (out_free),
      .res_load (res_load),
      .res      (res)
   );

   // output register: hold the result until the sink takes it
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = res_load || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.row_keys_held, rsp_ff.queued_count, rsp_ff.out_byte};
   assign rsp_tuser  = rsp_ff.out_valid;

endmodule
